>>> src/pwl_pkg.sv
// Package: shared types and constants for the piecewise-linear weight block.
`default_nettype none
package pwl_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_CMP_FIRST,
        ST_CMP_LAST,
        ST_RD_MID,
        ST_CMP_MID,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV,
        ST_EMIT
    } t_state;

    // table depth and weight format are tied to the 6-bit index and 16-bit weight fields
    localparam int MAX_KEYPOINTS    = 64;
    localparam int WEIGHT_FRAC_BITS = 15;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [0:0] CFG_KEYPOINT_COUNT = 1'd0;
    localparam logic [0:0] CFG_EXPAND_EXACT   = 1'd1;
endpackage
`default_nettype wire

>>> src/pwl_interpolation_weights.sv
// Top level: keypoint table, binary search, bit-serial divider and result sequencer.
// A write goes into the table when accepted; a query runs end checks on the first and last
// keypoints, a binary search that stops on an exact match, two span reads and a bit-serial
// division. Only one item is in work at a time; results go out one per cycle while
// m_axis_tready is high, and the input reopens the cycle after the last result leaves.
// Reset (synchronous, active low) sets keypoint_count to 1 and expand_exact to 1.
`default_nettype none
module pwl_interpolation_weights
    import pwl_pkg::*;
#(
    parameter int VALUE_WIDTH      = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata: keypoint_index [5:0], then sample_value [VW+5:6], zero fill
    input  wire logic [((VALUE_WIDTH+6+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata: point index [5:0], weight [21:6], zero fill to 24 bits
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(MAX_KEYPOINTS);
    localparam int CW = AW + 1;
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS;

    // configuration
    logic [6:0] r_count;
    logic       r_expand;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 7'd1;
            r_expand <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEYPOINT_COUNT: r_count  <= i_cfg_data;
                CFG_EXPAND_EXACT:   r_expand <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped count, minus one
    logic [CW-1:0] w_last;
    always_comb begin
        if (r_count == 7'd0) w_last = '0;
        else if (32'(r_count) > MAX_KEYPOINTS) w_last = CW'(MAX_KEYPOINTS - 1);
        else w_last = CW'(r_count - 7'd1);
    end

    // keypoint memory, one read port with registered data
    logic [VALUE_WIDTH-1:0] r_mem [MAX_KEYPOINTS];
    logic [VALUE_WIDTH-1:0] r_rd;
    logic [AW-1:0]          n_raddr;
    logic                   w_accept;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [5:0]             w_in_idx;
    assign w_in_idx = s_axis_tdata[5:0];
    assign w_in_val = s_axis_tdata[VALUE_WIDTH+5:6];
    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == OP_WRITE && 32'(w_in_idx) < MAX_KEYPOINTS)
            r_mem[AW'(w_in_idx)] <= w_in_val;
        r_rd <= r_mem[n_raddr];
    end

    t_state r_state, n_state;
    logic [VALUE_WIDTH:0]   r_x, n_x;     // order-preserving key
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [VALUE_WIDTH:0]   r_klo, n_klo;
    logic [VALUE_WIDTH:0]   r_rem, n_rem, r_den, n_den;
    logic [WW-1:0]          r_q, n_q;
    logic [4:0]             r_bit, n_bit;
    logic [1:0]             r_k, n_k;
    logic                   r_single, n_single;
    logic [CW-1:0]          r_sidx, n_sidx;
    logic [5:0]             r_oidx, n_oidx;
    logic [15:0]            r_ow, n_ow;
    logic                   r_olast, n_olast, r_ovalid, n_ovalid;

    logic [VALUE_WIDTH:0] w_rk, w_sh, w_diff;
    assign w_rk   = {1'b0, r_rd ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH-1))};
    assign w_sh   = {r_rem[VALUE_WIDTH-1:0], 1'b0};
    assign w_diff = w_sh - r_den;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_ow, r_oidx};
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_x <= n_x; r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid; r_klo <= n_klo;
        r_rem <= n_rem; r_den <= n_den; r_q <= n_q; r_bit <= n_bit; r_k <= n_k;
        r_single <= n_single; r_sidx <= n_sidx;
        r_oidx <= n_oidx; r_ow <= n_ow; r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state; n_x = r_x; n_lo = r_lo; n_hi = r_hi; n_mid = r_mid;
        n_klo = r_klo; n_rem = r_rem; n_den = r_den; n_q = r_q; n_bit = r_bit;
        n_k = r_k; n_single = r_single; n_sidx = r_sidx;
        n_oidx = r_oidx; n_ow = r_ow; n_olast = r_olast; n_ovalid = r_ovalid;
        n_raddr = AW'(r_mid);
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_raddr = '0;
                if (w_accept && s_axis_tuser == OP_QUERY) begin
                    n_x = {1'b0, w_in_val ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH-1))};
                    n_state = ST_CMP_FIRST;
                end
            end
            ST_RD_FIRST: begin
                n_raddr = '0;
                n_state = ST_CMP_FIRST;
            end
            ST_CMP_FIRST: begin
                n_raddr = AW'(w_last);
                if (r_x <= w_rk) begin
                    n_single = 1'b1; n_sidx = '0; n_k = '0; n_state = ST_EMIT;
                end else n_state = ST_CMP_LAST;
            end
            ST_CMP_LAST: begin
                if (w_last == '0 || r_x >= w_rk) begin
                    n_single = 1'b1; n_sidx = w_last; n_k = '0; n_state = ST_EMIT;
                end else begin
                    n_lo = '0; n_hi = w_last + CW'(1);
                    n_mid = CW'((CW+1)'(w_last + CW'(1)) >> 1);
                    n_state = ST_RD_MID;
                end
            end
            ST_RD_MID: begin
                n_raddr = AW'(r_mid);
                n_state = ST_CMP_MID;
            end
            ST_CMP_MID: begin
                if (r_x == w_rk) begin
                    n_single = 1'b1; n_sidx = r_mid; n_k = '0; n_state = ST_EMIT;
                end else begin
                    if (r_x > w_rk) n_lo = r_mid; else n_hi = r_mid;
                    if ((r_x > w_rk ? r_hi : r_mid) > (r_x > w_rk ? r_mid : r_lo) + CW'(1)) begin
                        n_mid = CW'(((CW+1)'(n_lo) + (CW+1)'(n_hi)) >> 1);
                        n_raddr = AW'(n_mid);
                        n_state = ST_CMP_MID;
                    end else begin
                        n_raddr = AW'(n_lo);
                        n_state = ST_RD_LO;
                    end
                end
            end
            ST_RD_LO: begin
                n_klo = w_rk;
                n_rem = r_x - w_rk;
                n_raddr = AW'(r_lo + CW'(1));
                n_state = ST_RD_HI;
            end
            ST_RD_HI: begin
                n_den = w_rk - r_klo;
                n_q = '0; n_bit = '0; n_single = 1'b0;
                if (r_rem >= w_rk - r_klo) begin
                    n_q = ONE; n_k = '0; n_state = ST_EMIT;
                end else n_state = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step per cycle
                if (r_rem[VALUE_WIDTH] || w_sh >= r_den) begin
                    n_rem = w_diff; n_q = {r_q[WW-2:0], 1'b1};
                end else begin
                    n_rem = w_sh; n_q = {r_q[WW-2:0], 1'b0};
                end
                n_bit = r_bit + 5'd1;
                if (32'(r_bit) == WEIGHT_FRAC_BITS - 1) begin
                    n_k = '0; n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_k = r_k + 2'd1;
                    if (!r_single) begin
                        n_oidx = 6'(r_lo + CW'(r_k));
                        n_ow = 16'(r_k == 2'd0 ? ONE - r_q : r_q);
                        n_olast = (r_k == 2'd1);
                    end else if (!r_expand || w_last == '0) begin
                        n_oidx = 6'(r_sidx); n_ow = 16'(ONE); n_olast = 1'b1;
                    end else if (r_sidx == '0) begin
                        n_oidx = 6'(r_k); n_ow = (r_k == 2'd0) ? 16'(ONE) : 16'd0;
                        n_olast = (r_k == 2'd1);
                    end else if (r_sidx == w_last) begin
                        n_oidx = 6'(w_last - CW'(1) + CW'(r_k));
                        n_ow = (r_k == 2'd1) ? 16'(ONE) : 16'd0;
                        n_olast = (r_k == 2'd1);
                    end else begin
                        n_oidx = 6'(r_sidx - CW'(1) + CW'(r_k));
                        n_ow = (r_k == 2'd1) ? 16'(ONE) : 16'd0;
                        n_olast = (r_k == 2'd2);
                    end
                    if (n_olast) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
